### design/knsup_pkg.sv
// ----------------------------------------------------------------------------
// knsup_pkg
// Shared types and constants of the keypoint neighbourhood suppressor.
// ----------------------------------------------------------------------------
package knsup_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned EXT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CMP_W      = 14;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MASK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic eval_en;
    logic wr_en;
    logic clr_start;
    logic clr_step;
    logic push;
  } knsup_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             clr_last;
  } knsup_sts_t;

endpackage

### design/knsup_datapath.sv
// ----------------------------------------------------------------------------
// knsup_datapath
// Four row banks of the occupancy map, neighbourhood test and marking,
// clearing sweep, configuration registers and result register.
// ----------------------------------------------------------------------------
module knsup_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [knsup_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [knsup_pkg::EXT_W-1:0]         cfg_data_i,
  input  logic [knsup_pkg::REQ_W-1:0]         req_type_i,
  input  logic [knsup_pkg::POS_W-1:0]         pos_x_i,
  input  logic [knsup_pkg::POS_W-1:0]         pos_y_i,
  input  logic                                mask_value_i,
  input  logic [knsup_pkg::TAG_W-1:0]         key_tag_i,
  input  knsup_pkg::knsup_cmd_t               cmd_i,
  output knsup_pkg::knsup_sts_t               sts_o,
  output logic [knsup_pkg::TAG_W-1:0]         result_tag_o,
  output logic                                keep_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned DEPTH = (MAX_HEIGHT + 3) / 4;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW  = knsup_pkg::CMP_W;

  logic [knsup_pkg::EXT_W-1:0] map_width_q, map_height_q;
  logic [knsup_pkg::REQ_W-1:0] req_q;
  logic [knsup_pkg::POS_W-1:0] x_q, y_q;
  logic                        mval_q;
  logic [knsup_pkg::TAG_W-1:0] tag_q;
  logic                        hit_q;
  logic [AW-1:0]               clr_cnt_q;
  logic [knsup_pkg::TAG_W-1:0] res_tag_q;
  logic                        res_keep_q;

  logic [CMPW-1:0] eff_w, eff_h, ext_w, ext_h;
  logic [CMPW-1:0] xp [3];
  logic [CMPW-1:0] xm [3];
  logic [CMPW-1:0] yp [3];
  logic [CMPW-1:0] ym [3];
  logic [2:0]      col_ok, row_ok;
  logic [CW-1:0]   col [3];
  logic [RW-1:0]   row [3];
  logic [MAX_WIDTH-1:0] col_mask, cell_mask;
  logic [AW-1:0]   bank_addr [4];
  logic [3:0]      bank_en, bank_we;
  logic [MAX_WIDTH-1:0] rd_q [4];
  logic [MAX_WIDTH-1:0] wdata [4];
  logic            is_query, is_mask, hit;

  assign is_query = (req_q == knsup_pkg::REQ_QUERY);
  assign is_mask  = (req_q == knsup_pkg::REQ_MASK);

  // effective extent
  assign ext_w = CMPW'(map_width_q);
  assign ext_h = CMPW'(map_height_q);
  assign eff_w = (ext_w < CMPW'(MAX_WIDTH))  ? ext_w : CMPW'(MAX_WIDTH);
  assign eff_h = (ext_h < CMPW'(MAX_HEIGHT)) ? ext_h : CMPW'(MAX_HEIGHT);

  // neighbour columns and rows, offset by one so that minus one stays unsigned
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xp[k]     = CMPW'(x_q) + CMPW'(k);
      xm[k]     = xp[k] - CMPW'(1);
      col_ok[k] = (xp[k] != '0) && (xp[k] <= eff_w);
      col[k]    = xm[k][CW-1:0];
      yp[k]     = CMPW'(y_q) + CMPW'(k);
      ym[k]     = yp[k] - CMPW'(1);
      row_ok[k] = (yp[k] != '0) && (yp[k] <= eff_h);
      row[k]    = ym[k][RW-1:0];
    end
  end

  always_comb begin
    col_mask  = '0;
    cell_mask = '0;
    for (int k = 0; k < 3; k++) begin
      if (col_ok[k]) begin
        col_mask[col[k]] = 1'b1;
      end
    end
    cell_mask[col[1]] = 1'b1;
  end

  // row y-1, y, y+1 fall into three different banks of four
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_addr[b] = '0;
      bank_en[b]   = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (row[k][1:0] == 2'(b)) begin
          bank_addr[b] = AW'(row[k] >> 2);
          if (is_query && row_ok[k]) begin
            bank_en[b] = 1'b1;
          end
          if (is_mask && (k == 1) && row_ok[k] && col_ok[1]) begin
            bank_en[b] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int b = 0; b < 4; b++) begin
      if (bank_en[b] && (|(rd_q[b] & col_mask))) begin
        hit = 1'b1;
      end
      if (cmd_i.clr_step) begin
        wdata[b] = '0;
      end else if (is_mask) begin
        wdata[b] = mval_q ? (rd_q[b] | cell_mask) : (rd_q[b] & ~cell_mask);
      end else begin
        wdata[b] = rd_q[b] | col_mask;
      end
      bank_we[b] = cmd_i.clr_step ||
                   (cmd_i.wr_en && bank_en[b] && (is_mask || (is_query && !hit_q)));
    end
  end

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [MAX_WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]        waddr;

    assign waddr = cmd_i.clr_step ? clr_cnt_q : bank_addr[gb];

    always_ff @(posedge clk_i) begin
      if (bank_we[gb]) begin
        mem[waddr] <= wdata[gb];
      end
      if (cmd_i.rd_en) begin
        rd_q[gb] <= mem[bank_addr[gb]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= knsup_pkg::EXT_W'(1024);
      map_height_q <= knsup_pkg::EXT_W'(1024);
      clr_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          knsup_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
          knsup_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      mval_q <= mask_value_i;
      tag_q  <= key_tag_i;
    end
    if (cmd_i.eval_en) begin
      hit_q <= hit;
    end
    if (cmd_i.push) begin
      res_tag_q  <= tag_q;
      res_keep_q <= !hit_q;
    end
  end

  assign sts_o.req      = req_q;
  assign sts_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
  assign result_tag_o   = res_tag_q;
  assign keep_o         = res_keep_q;

endmodule

### design/knsup_ctrl.sv
// ----------------------------------------------------------------------------
// knsup_ctrl
// Sequencer for one request at a time: read, test, write back, clear sweep,
// and the valid flag of the result register.
// ----------------------------------------------------------------------------
module knsup_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  knsup_pkg::knsup_sts_t sts_i,
  output knsup_pkg::knsup_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        if (sts_i.req == knsup_pkg::REQ_CLEAR) begin
          cmd_o.clr_start = 1'b1;
          state_d         = ST_CLEAR;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval_en = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts_i.req != knsup_pkg::REQ_QUERY) begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_IDLE;
        end else if (out_free) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.push  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && !sts_i.clr_last) |=> (state_q == ST_CLEAR))
    else $error("clearing sweep left early");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_READ))
    else $error("accepted transfer not sequenced");

  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_en && cmd_o.clr_step))
    else $error("write back during clearing sweep");
`endif

endmodule

### design/keypoint_neighbourhood_suppressor_top.sv
// ----------------------------------------------------------------------------
// keypoint_neighbourhood_suppressor_top
// Occupancy map based 3x3 suppression of keypoints with mask preload.
// ----------------------------------------------------------------------------
// A mask write or keypoint query runs through accept, one read of the four
// row banks (rows y-1, y, y+1 land in different banks), neighbourhood test
// and write back, and the next transfer is accepted only after write back.
// A clear request runs through accept, decode, then one bank row per cycle,
// and the pass that follows reset sweeps every bank row before the first
// transfer is accepted; configuration writes are taken at any time. A result
// waits in an output register, so a stalled result holds the input side only
// once a following query reaches write back.
module keypoint_neighbourhood_suppressor_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [knsup_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [knsup_pkg::EXT_W-1:0]          cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pos_x, pos_y, mask_value, key_tag, zero pad
  input  logic [knsup_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [knsup_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_tag, keep, zero pad
  output logic [knsup_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  knsup_pkg::knsup_cmd_t       cmd;
  knsup_pkg::knsup_sts_t       sts;
  logic [knsup_pkg::TAG_W-1:0] result_tag;
  logic                        keep;

  knsup_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  knsup_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (s_axis_tuser),
    .pos_x_i      (s_axis_tdata[9:0]),
    .pos_y_i      (s_axis_tdata[19:10]),
    .mask_value_i (s_axis_tdata[20]),
    .key_tag_i    (s_axis_tdata[36:21]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .result_tag_o (result_tag),
    .keep_o       (keep)
  );

  assign m_axis_tdata = {7'b0, keep, result_tag};

endmodule

### dv/knsup_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knsup_verdict_checker
// Watches the configuration port and both stream channels of the keypoint
// neighbourhood suppressor. Keeps its own occupancy map and map extent,
// predicts the keep/reject verdict of every accepted query and compares each
// result transfer, field by field, against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module knsup_verdict_checker #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [knsup_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [knsup_pkg::EXT_W-1:0]          cfg_data_i,
  input  logic                                 s_axis_tvalid_i,
  input  logic                                 s_axis_tready_i,
  // pos_x, pos_y, mask_value, key_tag, zero pad
  input  logic [knsup_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // req_type
  input  logic [knsup_pkg::REQ_W-1:0]          s_axis_tuser_i,
  input  logic                                 m_axis_tvalid_i,
  input  logic                                 m_axis_tready_i,
  // result_tag, keep, zero pad
  input  logic [knsup_pkg::OUT_DATA_W-1:0]     m_axis_tdata_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);

  typedef struct packed {
    logic [knsup_pkg::TAG_W-1:0] tag;
    logic                        keep;
  } verdict_t;

  bit                            occupied [int];
  logic [knsup_pkg::EXT_W-1:0]   width_q;
  logic [knsup_pkg::EXT_W-1:0]   height_q;
  verdict_t                      verdict_q [$];

  function automatic int unsigned clip_extent(logic [knsup_pkg::EXT_W-1:0] ext,
                                              int unsigned cap);
    return (ext < cap) ? int'(ext) : cap;
  endfunction

  // test or mark the in-bounds cells around (cx, cy)
  function automatic bit scan_block(int cx, int cy, bit mark);
    int  w;
    int  h;
    int  idx;
    bit  hit;
    w   = int'(clip_extent(width_q, MAX_WIDTH));
    h   = int'(clip_extent(height_q, MAX_HEIGHT));
    hit = 1'b0;
    for (int yy = cy - 1; yy <= cy + 1; yy++) begin
      if (yy < 0 || yy >= h) continue;
      for (int xx = cx - 1; xx <= cx + 1; xx++) begin
        if (xx < 0 || xx >= w) continue;
        idx = yy * int'(MAX_WIDTH) + xx;
        if (mark) begin
          occupied[idx] = 1'b1;
        end else if (occupied.exists(idx) && occupied[idx]) begin
          hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic void apply_request(logic [knsup_pkg::REQ_W-1:0] req,
                                        logic [knsup_pkg::POS_W-1:0] x,
                                        logic [knsup_pkg::POS_W-1:0] y,
                                        logic mval,
                                        logic [knsup_pkg::TAG_W-1:0] tag);
    verdict_t v;
    case (req)
      knsup_pkg::REQ_CLEAR: begin
        occupied.delete();
      end
      knsup_pkg::REQ_MASK: begin
        if (x < clip_extent(width_q, MAX_WIDTH) &&
            y < clip_extent(height_q, MAX_HEIGHT)) begin
          occupied[int'(y) * int'(MAX_WIDTH) + int'(x)] = mval;
        end
      end
      knsup_pkg::REQ_QUERY: begin
        v.tag  = tag;
        v.keep = !scan_block(int'(x), int'(y), 1'b0);
        if (v.keep) void'(scan_block(int'(x), int'(y), 1'b1));
        verdict_q = {verdict_q, v};
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      occupied.delete();
      verdict_q.delete();
      width_q      = knsup_pkg::EXT_W'(1024);
      height_q     = knsup_pkg::EXT_W'(1024);
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == knsup_pkg::CFG_MAP_WIDTH) begin
          width_q = cfg_data_i;
        end else if (cfg_idx_i == knsup_pkg::CFG_MAP_HEIGHT) begin
          height_q = cfg_data_i;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.tag  = m_axis_tdata_i[knsup_pkg::TAG_W-1:0];
        got.keep = m_axis_tdata_i[knsup_pkg::TAG_W];
        if (verdict_q.size() == 0) begin
          $error("result transfer with no query outstanding: result_tag %0h keep %0b",
                 got.tag, got.keep);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (got.tag !== want.tag) begin
            $error("result_tag mismatch: expected %0h, actual %0h", want.tag, got.tag);
            fail_count_o++;
          end
          if (got.keep !== want.keep) begin
            $error("keep mismatch: expected %0b, actual %0b", want.keep, got.keep);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_request(s_axis_tuser_i, s_axis_tdata_i[knsup_pkg::POS_W-1:0],
                      s_axis_tdata_i[2*knsup_pkg::POS_W-1:knsup_pkg::POS_W],
                      s_axis_tdata_i[2*knsup_pkg::POS_W],
                      s_axis_tdata_i[2*knsup_pkg::POS_W+knsup_pkg::TAG_W:
                                     2*knsup_pkg::POS_W+1]);
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

### dv/tb_keypoint_neighbourhood_suppressor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypoint_neighbourhood_suppressor_top
// Drives clears, mask writes and keypoint queries into the suppressor across
// a sweep of map extents, with random idling on both stream sides, a long
// result back-pressure stretch and full drains around each extent change.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_keypoint_neighbourhood_suppressor_top;

  localparam logic [knsup_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int SWEEP_LEN     = 12;
  localparam int SWEEP_BUDGET  = 80;

  localparam int sweep_width  [SWEEP_LEN] = '{16, 1, 1024, 2047, 0, 5, 1024, 3, 40, 9, 2, 24};
  localparam int sweep_height [SWEEP_LEN] = '{12, 1, 1024, 2047, 9, 3, 2, 1024, 33, 0, 2, 25};

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [knsup_pkg::CFG_IDX_W-1:0]      cfg_idx_i;
  logic [knsup_pkg::EXT_W-1:0]          cfg_data_i;
  logic                                 s_axis_tvalid;
  logic                                 s_axis_tready;
  logic [knsup_pkg::IN_DATA_W-1:0]      s_axis_tdata;
  logic [knsup_pkg::REQ_W-1:0]          s_axis_tuser;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready;
  logic [knsup_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

  int fail_count;
  int pending_verdicts;
  int src_idle_pct;
  int sink_idle_pct;
  bit hold_off_req;

  keypoint_neighbourhood_suppressor_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  knsup_verdict_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending_verdicts)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4_000_000);
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  task automatic send_req(logic [knsup_pkg::REQ_W-1:0] req,
                          logic [knsup_pkg::POS_W-1:0] x,
                          logic [knsup_pkg::POS_W-1:0] y,
                          logic mval, logic [knsup_pkg::TAG_W-1:0] tag);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, tag, mval, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering, wait for every outstanding verdict, let clears finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_extent(int w, int h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= knsup_pkg::CFG_MAP_WIDTH;
    cfg_data_i <= knsup_pkg::EXT_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= knsup_pkg::CFG_MAP_HEIGHT;
    cfg_data_i <= knsup_pkg::EXT_W'(h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [knsup_pkg::POS_W-1:0] pick_pos(int eff, int base);
    if (eff <= 24) return knsup_pkg::POS_W'($urandom_range(eff + 1, 0));
    return knsup_pkg::POS_W'(base + $urandom_range(15, 0));
  endfunction

  // frames of clear, mask preload and clustered queries
  task automatic run_frames(int w, int h, int budget);
    int sent;
    int eff_w;
    int eff_h;
    int base_x;
    int base_y;
    int roll;
    eff_w = (w > 1024) ? 1024 : w;
    eff_h = (h > 1024) ? 1024 : h;
    sent  = 0;
    while (sent < budget) begin
      base_x = (eff_w > 24) ? $urandom_range((eff_w - 14 > 1008) ? 1008 : eff_w - 14, 0) : 0;
      base_y = (eff_h > 24) ? $urandom_range((eff_h - 14 > 1008) ? 1008 : eff_h - 14, 0) : 0;
      if ($urandom_range(9, 0) != 0) begin
        send_req(knsup_pkg::REQ_CLEAR, knsup_pkg::POS_W'($urandom),
                 knsup_pkg::POS_W'($urandom), 1'($urandom),
                 knsup_pkg::TAG_W'($urandom));
        sent++;
      end
      repeat ($urandom_range(3, 0)) begin
        send_req(knsup_pkg::REQ_MASK, pick_pos(eff_w, base_x), pick_pos(eff_h, base_y),
                 1'($urandom), knsup_pkg::TAG_W'($urandom));
        sent++;
      end
      repeat ($urandom_range(30, 6)) begin
        roll = $urandom_range(99, 0);
        if (roll < 4) begin
          send_req(REQ_UNUSED, knsup_pkg::POS_W'($urandom), knsup_pkg::POS_W'($urandom),
                   1'($urandom), knsup_pkg::TAG_W'($urandom));
        end else if (roll < 10) begin
          send_req(knsup_pkg::REQ_QUERY, knsup_pkg::POS_W'($urandom),
                   knsup_pkg::POS_W'($urandom), 1'($urandom),
                   knsup_pkg::TAG_W'($urandom));
          sent++;
        end else begin
          send_req(knsup_pkg::REQ_QUERY, pick_pos(eff_w, base_x), pick_pos(eff_h, base_y),
                   1'($urandom), knsup_pkg::TAG_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= knsup_pkg::CFG_MAP_WIDTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= knsup_pkg::REQ_CLEAR;
    hold_off_req  = 1'b0;
    src_idle_pct  = 17;
    sink_idle_pct = 65;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, repeats, mask preload, unused type, clear
    send_req(knsup_pkg::REQ_QUERY, 10'd0, 10'd0, 1'b0, 16'h0000);
    send_req(knsup_pkg::REQ_QUERY, 10'd1, 10'd1, 1'b1, 16'hFFFF);
    send_req(knsup_pkg::REQ_QUERY, 10'd1023, 10'd1023, 1'b0, 16'h8001);
    send_req(knsup_pkg::REQ_QUERY, 10'd1021, 10'd1021, 1'b0, 16'h7FFE);
    send_req(knsup_pkg::REQ_QUERY, 10'd512, 10'd0, 1'b0, 16'h5555);
    send_req(knsup_pkg::REQ_QUERY, 10'd0, 10'd700, 1'b0, 16'hAAAA);
    send_req(knsup_pkg::REQ_MASK, 10'd500, 10'd500, 1'b1, 16'h0001);
    send_req(knsup_pkg::REQ_QUERY, 10'd501, 10'd499, 1'b0, 16'h1234);
    send_req(knsup_pkg::REQ_MASK, 10'd500, 10'd500, 1'b0, 16'h0002);
    send_req(knsup_pkg::REQ_QUERY, 10'd501, 10'd499, 1'b0, 16'h4321);
    send_req(REQ_UNUSED, 10'd1023, 10'd1023, 1'b1, 16'hFFFF);
    send_req(knsup_pkg::REQ_CLEAR, 10'd1023, 10'd1023, 1'b1, 16'hFFFF);
    send_req(knsup_pkg::REQ_QUERY, 10'd1, 10'd1, 1'b0, 16'h0F0F);
    drain();

    // out-of-bounds mask write and centre, then the extent grows mid-frame
    set_extent(8, 6);
    send_req(knsup_pkg::REQ_MASK, 10'd20, 10'd3, 1'b1, 16'h0003);
    send_req(knsup_pkg::REQ_QUERY, 10'd8, 10'd3, 1'b0, 16'h0100);
    send_req(knsup_pkg::REQ_QUERY, 10'd9, 10'd3, 1'b0, 16'h0101);
    drain();
    set_extent(1024, 1024);
    send_req(knsup_pkg::REQ_QUERY, 10'd21, 10'd3, 1'b0, 16'h0102);
    send_req(knsup_pkg::REQ_QUERY, 10'd9, 10'd3, 1'b0, 16'h0103);
    send_req(knsup_pkg::REQ_QUERY, 10'd6, 10'd3, 1'b0, 16'h0104);
    drain();

    // zero width: everything kept
    set_extent(0, 1024);
    send_req(knsup_pkg::REQ_QUERY, 10'd5, 10'd5, 1'b0, 16'h0200);
    send_req(knsup_pkg::REQ_QUERY, 10'd5, 10'd5, 1'b0, 16'h0201);
    drain();

    for (int i = 0; i < SWEEP_LEN; i++) begin
      if (i < 4) begin
        src_idle_pct  = 17;
        sink_idle_pct = 65;
      end else if (i < 8) begin
        src_idle_pct  = 65;
        sink_idle_pct = 17;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      set_extent(sweep_width[i], sweep_height[i]);
      if (i == 1) hold_off_req = 1'b1;
      run_frames(sweep_width[i], sweep_height[i], SWEEP_BUDGET);
      drain();
    end

    if (fail_count == 0 && pending_verdicts == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
design/knsup_pkg.sv
design/knsup_datapath.sv
design/knsup_ctrl.sv
design/keypoint_neighbourhood_suppressor_top.sv
dv/knsup_verdict_checker.sv
dv/tb_keypoint_neighbourhood_suppressor_top.sv
